[design/pastel_gradient_color_core_defines.svh]
// Assertion macros shared by the checker.
`ifndef PASTEL_GRADIENT_COLOR_CORE_DEFINES_SVH
`define PASTEL_GRADIENT_COLOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PGC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PGC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pgc_pkg.sv]
`timescale 1ns / 1ps

package pgc_pkg;

    localparam int FRACTION_BITS = 16;
    localparam logic [16:0] FX_ONE = 17'h10000;
    localparam logic [15:0] FX_HALF = 16'h8000;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_HUE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DISCRETE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_JOINING = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SEGMENTS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CLASSES = 3'd4;

    typedef enum logic [1:0] {
        JOIN_NONE,
        JOIN_STEPS,
        JOIN_TUBES,
        JOIN_DIVERGING
    } join_kind_t;

    typedef struct packed {
        logic [15:0] hue;
        logic        discrete;
        join_kind_t  join_kind;
        logic [6:0]  segments;
        logic [6:0]  classes;
    } cfg_t;

    typedef struct packed {
        logic [16:0] p;
        logic [2:0]  sector;
        logic [15:0] f;
    } shape_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [16:0] p;
    } rgb_t;

endpackage

[design/pastel_gradient_color_core.sv]
`timescale 1ns / 1ps
// Pastel gradient colormap core.
// Slave stream: one 16-bit gradient position (Q0.16) per word on s_tdata.
// Master stream: one pixel per word on m_tdata: red, green, blue, luma and
// the 17-bit shaped position.
// Configuration: cfg_we / cfg_index / cfg_wdata, to be written only when
// the core is idle (the user's duty; the core does not enforce it); index 0
// hue, 1 discrete mode, 2 joining kind, 3 segment count, 4 class count.
// Pipeline: a register stage each for joining, class index, quantise,
// saturation, levels, channels and luma, from input word to output word.
// Throughput: one word per cycle while m_tready is high; every stage
// carries its own valid bit. Each stage advances while it is empty or the
// stage after it moves, so bubbles close up; s_tready follows m_tready
// combinationally through that chain. A stalled receiver holds the output
// word stable and fills the pipeline; nothing is dropped or repeated.
// Reset: synchronous, active low; empties the pipeline and loads the
// register defaults (hue 0, continuous, no joining, 4 segments, 7 classes).
module pastel_gradient_color_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // position[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // red, green, blue, luma, shaped_position, pad
);

    logic [15:0]         hue_reg;
    logic                discrete_reg;
    pgc_pkg::join_kind_t join_reg;
    logic [6:0]          segments_reg;
    logic [6:0]          classes_reg;
    pgc_pkg::cfg_t       cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_reg      <= 16'd0;
            discrete_reg <= 1'b0;
            join_reg     <= pgc_pkg::JOIN_NONE;
            segments_reg <= 7'd4;
            classes_reg  <= 7'd7;
        end else if (cfg_we) begin
            case (cfg_index)
                pgc_pkg::REG_HUE:      hue_reg      <= cfg_wdata;
                pgc_pkg::REG_DISCRETE: discrete_reg <= cfg_wdata[0];
                pgc_pkg::REG_JOINING:  join_reg     <= pgc_pkg::join_kind_t'(cfg_wdata[1:0]);
                pgc_pkg::REG_SEGMENTS: segments_reg <= cfg_wdata[6:0];
                pgc_pkg::REG_CLASSES:  classes_reg  <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign cfg.hue       = hue_reg;
    assign cfg.discrete  = discrete_reg;
    assign cfg.join_kind = join_reg;
    assign cfg.segments  = segments_reg;
    assign cfg.classes   = classes_reg;

    logic            sh_valid, sh_ready;
    pgc_pkg::shape_t sh_data;
    logic            rgb_valid, rgb_ready;
    pgc_pkg::rgb_t   rgb_data;

    pgc_shape u_shape (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pos    (s_tdata),
        .out_valid (sh_valid),
        .out_ready (sh_ready),
        .out_data  (sh_data)
    );

    pgc_hsv u_hsv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sh_valid),
        .in_ready  (sh_ready),
        .in_data   (sh_data),
        .out_valid (rgb_valid),
        .out_ready (rgb_ready),
        .out_data  (rgb_data)
    );

    pgc_luma u_luma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rgb_valid),
        .in_ready  (rgb_ready),
        .in_data   (rgb_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata)
    );

endmodule

[design/pgc_shape.sv]
`timescale 1ns / 1ps

module pgc_shape (
    input  logic            aclk,
    input  logic            aresetn,
    input  pgc_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [15:0]     in_pos,
    output logic            out_valid,
    input  logic            out_ready,
    output pgc_pkg::shape_t out_data
);

    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W = RECIP_SHIFT + 1;
    localparam int CLS_DEPTH = 128;

    logic [RECIP_W-1:0] recip_tbl [CLS_DEPTH];
    logic [RECIP_W-1:0] recip_reg;

    for (genvar i = 0; i < CLS_DEPTH; i++) begin : g_recip
        localparam longint D = (i == 0) ? 64'd1 : 64'(i);
        localparam logic [RECIP_W-1:0] R =
            RECIP_W'(((64'd1 << RECIP_SHIFT) + D - 64'd1) / D);
        assign recip_tbl[i] = R;
    end

    logic a_vld_reg, b_vld_reg, c_vld_reg;
    logic a_ready, b_ready, c_ready;

    assign c_ready  = !c_vld_reg || out_ready;
    assign b_ready  = !b_vld_reg || c_ready;
    assign a_ready  = !a_vld_reg || b_ready;
    assign in_ready = a_ready;

    // stage A: joining mode
    logic [22:0] a_prod;
    logic [16:0] a_frac;
    logic [17:0] a_twice;
    logic [17:0] a_fold;
    logic [16:0] a_p_next;
    logic [15:0] a_h_next;
    logic [16:0] a_p_reg;
    logic [15:0] a_h_reg;

    assign a_prod  = 23'(in_pos) * 23'(cfg.segments);
    assign a_frac  = {1'b0, a_prod[15:0]};
    assign a_twice = {1'b0, in_pos, 1'b0};
    assign a_fold  = (a_twice > 18'(pgc_pkg::FX_ONE)) ?
                     (18'(pgc_pkg::FX_ONE) << 1) - a_twice : a_twice;

    always_comb begin
        case (cfg.join_kind)
            pgc_pkg::JOIN_STEPS: begin
                a_p_next = a_frac;
            end
            pgc_pkg::JOIN_TUBES: begin
                a_p_next = a_prod[16] ? pgc_pkg::FX_ONE - a_frac : a_frac;
            end
            pgc_pkg::JOIN_DIVERGING: begin
                a_p_next = 17'(18'(pgc_pkg::FX_ONE) - a_fold);
            end
            default: begin
                a_p_next = {1'b0, in_pos};
            end
        endcase
    end

    assign a_h_next = (cfg.join_kind == pgc_pkg::JOIN_DIVERGING && in_pos > pgc_pkg::FX_HALF) ?
                      cfg.hue + pgc_pkg::FX_HALF : cfg.hue;

    // stage B: class index and hue sector
    logic [6:0]  b_cls;
    logic [23:0] b_kprod;
    logic [18:0] b_h6;
    logic [16:0] b_p_reg;
    logic [6:0]  b_k_reg;
    logic [2:0]  b_sector_reg;
    logic [15:0] b_f_reg;

    assign b_cls   = (cfg.classes == 7'd0) ? 7'd1 : cfg.classes;
    assign b_kprod = 24'(a_p_reg) * 24'(b_cls);
    assign b_h6    = 19'(a_h_reg) * 19'd6;

    // stage C: quantised position via reciprocal
    logic [37:0] c_qprod;
    logic [16:0] c_p_next;

    assign c_qprod  = 38'(b_k_reg) * 38'(recip_reg);
    assign c_p_next = cfg.discrete ? c_qprod[RECIP_SHIFT:RECIP_SHIFT-16] : b_p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            if (a_ready) a_vld_reg <= in_valid;
            if (b_ready) b_vld_reg <= a_vld_reg;
            if (c_ready) c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        recip_reg <= recip_tbl[cfg.classes];
        if (a_ready && in_valid) begin
            a_p_reg <= a_p_next;
            a_h_reg <= a_h_next;
        end
        if (b_ready && a_vld_reg) begin
            b_p_reg      <= a_p_reg;
            b_k_reg      <= b_kprod[22:16];
            b_sector_reg <= b_h6[18:16];
            b_f_reg      <= b_h6[15:0];
        end
        if (c_ready && b_vld_reg) begin
            out_data.p      <= c_p_next;
            out_data.sector <= b_sector_reg;
            out_data.f      <= b_f_reg;
        end
    end

    assign out_valid = c_vld_reg;

endmodule

[design/pgc_hsv.sv]
`timescale 1ns / 1ps

module pgc_hsv (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  pgc_pkg::shape_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output pgc_pkg::rgb_t   out_data
);

    // floor(3p/5) as p * SAT_MUL >> 21, SAT_MUL = ceil(3 * 2^21 / 5) + 1
    localparam logic [20:0] SAT_MUL = 21'd1258293;
    localparam int SAT_SHIFT = 21;

    localparam logic [2:0] SECT_RED_UP = 3'd0;
    localparam logic [2:0] SECT_GREEN_HI = 3'd1;
    localparam logic [2:0] SECT_BLUE_UP = 3'd2;
    localparam logic [2:0] SECT_BLUE_HI = 3'd3;
    localparam logic [2:0] SECT_RED_DN = 3'd4;

    function automatic logic [7:0] to_channel(input logic [16:0] x);
        logic [24:0] w;
        w = {x, 8'b0} - 25'(x);
        return w[23:16];
    endfunction

    logic d_vld_reg, e_vld_reg, f_vld_reg;
    logic d_ready, e_ready, f_ready;

    assign f_ready  = !f_vld_reg || out_ready;
    assign e_ready  = !e_vld_reg || f_ready;
    assign d_ready  = !d_vld_reg || e_ready;
    assign in_ready = d_ready;

    // stage D: saturation
    logic [37:0] d_prod;
    logic [15:0] d_s_reg;
    logic [15:0] d_f_reg;
    logic [2:0]  d_sector_reg;
    logic [16:0] d_p_reg;

    assign d_prod = 38'(in_data.p) * 38'(SAT_MUL);

    // stage E: P, Q, T levels
    logic [31:0] e_sf;
    logic [32:0] e_sg;
    logic [16:0] e_cp_reg, e_cq_reg, e_ct_reg;
    logic [2:0]  e_sector_reg;
    logic [16:0] e_p_reg;

    assign e_sf = 32'(d_s_reg) * 32'(d_f_reg);
    assign e_sg = 33'(d_s_reg) * 33'(pgc_pkg::FX_ONE - {1'b0, d_f_reg});

    // stage F: sector select and 8-bit channels
    logic [16:0] f_r, f_g, f_b;

    always_comb begin
        case (e_sector_reg)
            SECT_RED_UP: begin
                f_r = pgc_pkg::FX_ONE; f_g = e_ct_reg; f_b = e_cp_reg;
            end
            SECT_GREEN_HI: begin
                f_r = e_cq_reg; f_g = pgc_pkg::FX_ONE; f_b = e_cp_reg;
            end
            SECT_BLUE_UP: begin
                f_r = e_cp_reg; f_g = pgc_pkg::FX_ONE; f_b = e_ct_reg;
            end
            SECT_BLUE_HI: begin
                f_r = e_cp_reg; f_g = e_cq_reg; f_b = pgc_pkg::FX_ONE;
            end
            SECT_RED_DN: begin
                f_r = e_ct_reg; f_g = e_cp_reg; f_b = pgc_pkg::FX_ONE;
            end
            default: begin
                f_r = pgc_pkg::FX_ONE; f_g = e_cp_reg; f_b = e_cq_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end else begin
            if (d_ready) d_vld_reg <= in_valid;
            if (e_ready) e_vld_reg <= d_vld_reg;
            if (f_ready) f_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready && in_valid) begin
            d_s_reg      <= d_prod[SAT_SHIFT+15:SAT_SHIFT];
            d_f_reg      <= in_data.f;
            d_sector_reg <= in_data.sector;
            d_p_reg      <= in_data.p;
        end
        if (e_ready && d_vld_reg) begin
            e_cp_reg     <= pgc_pkg::FX_ONE - {1'b0, d_s_reg};
            e_cq_reg     <= pgc_pkg::FX_ONE - {1'b0, e_sf[31:16]};
            e_ct_reg     <= pgc_pkg::FX_ONE - e_sg[32:16];
            e_sector_reg <= d_sector_reg;
            e_p_reg      <= d_p_reg;
        end
        if (f_ready && e_vld_reg) begin
            out_data.red   <= to_channel(f_r);
            out_data.green <= to_channel(f_g);
            out_data.blue  <= to_channel(f_b);
            out_data.p     <= e_p_reg;
        end
    end

    assign out_valid = f_vld_reg;

endmodule

[design/pgc_luma.sv]
`timescale 1ns / 1ps

module pgc_luma (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  pgc_pkg::rgb_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [55:0]   out_word
);

    localparam logic [15:0] LUMA_R = 16'd77;
    localparam logic [15:0] LUMA_G = 16'd150;
    localparam logic [15:0] LUMA_B = 16'd29;

    logic        vld_reg;
    logic [15:0] luma_sum;
    logic [55:0] word_reg;

    assign in_ready = !vld_reg || out_ready;
    assign luma_sum = 16'(in_data.red) * LUMA_R + 16'(in_data.green) * LUMA_G
                    + 16'(in_data.blue) * LUMA_B;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= {7'b0, in_data.p, luma_sum[15:8],
                         in_data.blue, in_data.green, in_data.red};
        end
    end

    assign out_valid = vld_reg;
    assign out_word  = word_reg;

endmodule

[design/pgc_checker.sv]
`timescale 1ns / 1ps
`include "pastel_gradient_color_core_defines.svh"

module pgc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    `PGC_ASSERT_NOW(a_empty_after_reset, aclk, aresetn, $past(!aresetn), !m_tvalid, "word after reset")
    `PGC_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled word changed")
    `PGC_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[55:49] == 7'd0, "pad bits set")
    `PGC_ASSERT_NOW(a_shaped_range, aclk, aresetn, m_tvalid, !m_tdata[48] || m_tdata[47:32] == 16'd0, "shaped position above one")
    `PGC_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready, "input blocked with empty output")

endmodule

bind pastel_gradient_color_core pgc_checker u_pgc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
